/* rtl/per_label_boundary_fraction_defines.svh */
// Assertion macros for the per-label boundary fraction block.
// Used by the checker module; no other dependencies.
`ifndef PER_LABEL_BOUNDARY_FRACTION_DEFINES_SVH
`define PER_LABEL_BOUNDARY_FRACTION_DEFINES_SVH

// Clocked assertion, masked while reset is high.
`define PLBF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define PLBF_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/plbf_pkg.sv */
// Shared types and constants for the per-label boundary fraction block.
// No dependencies.
`timescale 1ns / 1ps

package plbf_pkg;

  localparam int MAX_LABELS_DEF = 1024;
  localparam int COUNT_BITS_DEF = 32;

  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] LABELS_RESET = 11'd1024;

  localparam int LABEL_W = 10;
  localparam int REPORT_W = 32;

  // Q1.16 fraction; one extra quotient bit is produced for rounding.
  localparam int FRAC_W = 17;
  localparam int Q_BITS = FRAC_W + 1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic               mode;
    logic [LABEL_W-1:0] label;
    logic               on_boundary;
  } in_item_t;

  typedef struct packed {
    logic [FRAC_W-1:0]   fraction;
    logic [1:0]          status;
    logic [REPORT_W-1:0] total_cells;
    logic [REPORT_W-1:0] edge_cells;
  } out_item_t;

  typedef struct packed {
    logic active;
    logic done;
  } div_stat_t;

endpackage

/* rtl/plbf_tally_ram.sv */
// Tally store: one write port, one read port, registered read data.
// Depends on plbf_pkg for default sizes.
`timescale 1ns / 1ps

module plbf_tally_ram #(
  parameter int DEPTH  = plbf_pkg::MAX_LABELS_DEF,
  parameter int WIDTH  = 2 * plbf_pkg::COUNT_BITS_DEF,
  parameter int ADDR_W = $clog2(plbf_pkg::MAX_LABELS_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write: a same-edge write is not seen here
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/plbf_divider.sv */
// Restoring divider giving round(num * 2^16 / den), ties up, for num <= den.
// One quotient bit per cycle. Depends on plbf_pkg.
`timescale 1ns / 1ps

module plbf_divider #(
  parameter int COUNT_BITS = plbf_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [COUNT_BITS-1:0]         num,
  input  logic [COUNT_BITS-1:0]         den,
  output plbf_pkg::div_stat_t           stat,
  output logic [plbf_pkg::FRAC_W-1:0]   frac
);

  localparam int QB    = plbf_pkg::Q_BITS;
  localparam int CNT_W = $clog2(QB);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(QB - 1);

  logic                  active;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [COUNT_BITS-1:0] r;
  logic [COUNT_BITS-1:0] d;
  logic [QB-1:0]         q;

  logic [COUNT_BITS:0]   rs;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;
  logic [COUNT_BITS-1:0] r_next;

  // first step takes the integer bit, so no shift
  always_comb begin
    rs     = (cnt == '0) ? {1'b0, r} : {r, 1'b0};
    diff   = rs - {1'b0, d};
    ge     = (rs >= {1'b0, d});
    r_next = ge ? diff[COUNT_BITS-1:0] : rs[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        r      <= num;
        d      <= den;
        q      <= '0;
      end else if (active) begin
        r   <= r_next;
        q   <= {q[QB-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // low bit of q is the rounding bit; the sum cannot pass 1.0
  assign frac = plbf_pkg::FRAC_W'(q[QB-1:1]) + plbf_pkg::FRAC_W'(q[0]);

  always_comb begin
    stat.active = active;
    stat.done   = done;
  end

endmodule

/* rtl/per_label_boundary_fraction.sv */
// Top level of the per-label boundary fraction block: tally store
// read-modify-write pipeline and read result path.
// Depends on plbf_pkg, plbf_tally_ram and plbf_divider.
`timescale 1ns / 1ps

// Usage
//   Command channel: cmd is taken at a rising edge with start high and busy
//   low. mode 0 counts one cell against its label, mode 1 reads a label.
//   Count transactions go back to back, one per cycle while busy is low; a same-label count in
//   the following cycle is forwarded from the last write.
//   Result channel: done is high for one cycle with result valid; there is
//   no back-pressure. Only reads give a result.
//   Reads: a read flagged as label zero, empty or out of range shows done
//   from the result register after the first stage. A normal read runs the
//   divider, one quotient bit per cycle over 18 steps, and shows done from
//   the result register after the divider ends. busy stays high until the
//   result register is loaded, so a new command waits for the read's result.
//   Configuration: cfg_we writes labels_in_use from cfg_data; write only
//   while idle.
//   Reset: the tally store is swept to zero, one entry a cycle, with busy
//   high; cfg writes are taken meanwhile.
module per_label_boundary_fraction #(
  parameter int MAX_LABELS = plbf_pkg::MAX_LABELS_DEF,
  parameter int COUNT_BITS = plbf_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  plbf_pkg::in_item_t           cmd,
  output logic                         done,
  output plbf_pkg::out_item_t          result,
  input  logic                         cfg_we,
  input  logic [plbf_pkg::CFG_W-1:0]   cfg_data
);

  localparam int ADDR_W = $clog2(MAX_LABELS);
  localparam int LIM_B  = $clog2(MAX_LABELS + 1);
  localparam int LIM_W  = (LIM_B > plbf_pkg::CFG_W) ? LIM_B : plbf_pkg::CFG_W;
  localparam int WB     = (COUNT_BITS > plbf_pkg::REPORT_W) ? COUNT_BITS
                                                            : plbf_pkg::REPORT_W;
  localparam int MW     = 2 * COUNT_BITS;
  localparam logic [LIM_W-1:0]  LIM_MAX  = LIM_W'(MAX_LABELS);
  localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(MAX_LABELS - 1);

  // configuration
  logic [plbf_pkg::CFG_W-1:0] labels_in_use;
  logic [LIM_W-1:0]           cfg_ext;
  logic [LIM_W-1:0]           limit;
  logic [LIM_W-1:0]           label_ext;
  logic                       accept;

  // clearing sweep
  logic              clr_active;
  logic [ADDR_W-1:0] clr_addr;

  // stage 1
  logic              s1_valid;
  logic              s1_mode;
  logic              s1_edge;
  logic              s1_inrange;
  logic              s1_zero;
  logic [ADDR_W-1:0] s1_addr;

  // last write, for forwarding
  logic              lw_valid;
  logic [ADDR_W-1:0] lw_addr;
  logic [MW-1:0]     lw_data;

  // memory ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [MW-1:0]     mem_wdata;
  logic [MW-1:0]     mem_rdata;

  logic [MW-1:0]         cur;
  logic [COUNT_BITS-1:0] cur_cell;
  logic [COUNT_BITS-1:0] cur_edge;
  logic [COUNT_BITS-1:0] cell_new;
  logic [COUNT_BITS-1:0] edge_new;
  logic [COUNT_BITS-1:0] div_num;
  logic                  cnt_we;
  logic                  s1_read;
  logic                  div_start;
  logic [WB-1:0]         cell_wide;
  logic [WB-1:0]         edge_wide;
  logic [1:0]            rd_status;

  // held counts while dividing
  logic [plbf_pkg::REPORT_W-1:0] hold_total;
  logic [plbf_pkg::REPORT_W-1:0] hold_edge;

  plbf_pkg::div_stat_t           div_stat;
  logic [plbf_pkg::FRAC_W-1:0]   div_frac;

  always_comb begin
    cfg_ext   = LIM_W'(labels_in_use);
    if (cfg_ext == '0) begin
      limit = LIM_W'(1);
    end else if (cfg_ext > LIM_MAX) begin
      limit = LIM_MAX;
    end else begin
      limit = cfg_ext;
    end
    label_ext = LIM_W'(cmd.label);
  end

  assign busy   = clr_active | (s1_valid & s1_mode) | div_stat.active | div_stat.done;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      labels_in_use <= plbf_pkg::LABELS_RESET;
    end else if (cfg_we) begin
      labels_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_TOP) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_mode    <= cmd.mode;
      s1_edge    <= cmd.on_boundary;
      s1_inrange <= (label_ext < limit);
      s1_zero    <= (cmd.label == '0);
      s1_addr    <= label_ext[ADDR_W-1:0];
    end
  end

  plbf_tally_ram #(
    .DEPTH  (MAX_LABELS),
    .WIDTH  (MW),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (label_ext[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  always_comb begin
    cur      = (lw_valid && lw_addr == s1_addr) ? lw_data : mem_rdata;
    cur_cell = cur[COUNT_BITS-1:0];
    cur_edge = cur[MW-1:COUNT_BITS];
    cell_new = (cur_cell == '1) ? cur_cell : cur_cell + 1'b1;
    edge_new = (s1_edge && cur_edge != '1) ? cur_edge + 1'b1 : cur_edge;
    cnt_we   = s1_valid & ~s1_mode & s1_inrange;

    mem_we    = clr_active | cnt_we;
    mem_waddr = clr_active ? clr_addr : s1_addr;
    mem_wdata = clr_active ? '0 : {edge_new, cell_new};

    s1_read   = s1_valid & s1_mode;
    div_start = s1_read & s1_inrange & ~s1_zero & (cur_cell != '0);
    div_num   = (cur_edge <= cur_cell) ? cur_edge : cur_cell;
    cell_wide = WB'(cur_cell);
    edge_wide = WB'(cur_edge);

    if (!s1_inrange) begin
      rd_status = plbf_pkg::ST_RANGE;
    end else if (s1_zero) begin
      rd_status = plbf_pkg::ST_ZERO;
    end else if (cur_cell == '0) begin
      rd_status = plbf_pkg::ST_EMPTY;
    end else begin
      rd_status = plbf_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr_active) begin
      lw_valid <= 1'b0;
    end else if (cnt_we) begin
      lw_valid <= 1'b1;
      lw_addr  <= s1_addr;
      lw_data  <= {edge_new, cell_new};
    end
  end

  plbf_divider #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (cur_cell),
    .stat  (div_stat),
    .frac  (div_frac)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (s1_read && !div_start) begin
        done            <= 1'b1;
        result.fraction <= '0;
        result.status   <= rd_status;
        if (s1_inrange) begin
          result.total_cells <= cell_wide[plbf_pkg::REPORT_W-1:0];
          result.edge_cells  <= edge_wide[plbf_pkg::REPORT_W-1:0];
        end else begin
          result.total_cells <= '0;
          result.edge_cells  <= '0;
        end
      end else if (div_stat.done) begin
        done               <= 1'b1;
        result.fraction    <= div_frac;
        result.status      <= plbf_pkg::ST_OK;
        result.total_cells <= hold_total;
        result.edge_cells  <= hold_edge;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      hold_total <= cell_wide[plbf_pkg::REPORT_W-1:0];
      hold_edge  <= edge_wide[plbf_pkg::REPORT_W-1:0];
    end
  end

endmodule

/* rtl/plbf_checker.sv */
// Port-level checks for per_label_boundary_fraction, bound to the top level.
// Depends on plbf_pkg and per_label_boundary_fraction_defines.svh.
`timescale 1ns / 1ps
`include "per_label_boundary_fraction_defines.svh"

module plbf_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input plbf_pkg::in_item_t  cmd,
  input logic                done,
  input plbf_pkg::out_item_t result
);

  logic read_taken;
  logic flagged;
  logic no_counts;
  logic counts_clear;

  assign read_taken   = start && !busy && cmd.mode;
  assign flagged      = done && result.status != plbf_pkg::ST_OK;
  assign no_counts    = done && (result.status == plbf_pkg::ST_EMPTY ||
                                 result.status == plbf_pkg::ST_RANGE);
  assign counts_clear = result.total_cells == '0 && result.edge_cells == '0;

  // the clearing sweep holds off commands straight after reset
  `PLBF_ASSERT_RST(a_busy_after_rst, clk, rst |=> busy, "not busy after reset")

  // a read transaction that is taken raises busy
  `PLBF_ASSERT(a_read_busy, clk, rst, read_taken |=> busy, "read not held off")

  `PLBF_ASSERT(a_frac_zero, clk, rst, flagged |-> result.fraction == '0, "fraction on flagged read")

  `PLBF_ASSERT(a_counts_zero, clk, rst, no_counts |-> counts_clear, "counts on empty or range read")

endmodule

bind per_label_boundary_fraction plbf_checker u_plbf_checker (.*);
